// ===== src/stvg_pkg.sv =====
// Shared types, codes and the sine polynomial for the swept tone voice generator.
package stvg_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_START_STEP   = 3'd0,
    CFG_STEP_SLOPE   = 3'd1,
    CFG_WAVE_SHAPE   = 3'd2,
    CFG_TONE_LENGTH  = 3'd3,
    CFG_TONE_VOLUME  = 3'd4,
    CFG_FILTER_ALPHA = 3'd5,
    CFG_DECAY_FACTOR = 3'd6,
    CFG_ATTACK_STEP  = 3'd7
  } cfg_index_e;

  // Wave shape codes; the unused code plays as sine.
  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [1:0] SHAPE_SAWTOOTH = 2'd2;

  localparam int unsigned CFG_DATA_W = 32;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_WAVE,
    ST_FMUL,
    ST_FUPD,
    ST_ENV,
    ST_DEC,
    ST_VMUL,
    ST_VSUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               start_req;
    logic signed [15:0] mix_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] mix_out;
    logic               voice_active;
    logic               tone_done;
  } out_t;

  // sin(pi/2 * u) for u in Q30 on [0, 2^30], result in Q30. Used at elaboration only.
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] t;
    u2 = (u * u) >> 30;
    t  = 64'd172273;
    t  = 64'd5026996 - ((u2 * t) >> 30);
    t  = 64'd85569306 - ((u2 * t) >> 30);
    t  = 64'd693598667 - ((u2 * t) >> 30);
    t  = 64'd1686629713 - ((u2 * t) >> 30);
    return (u * t) >> 30;
  endfunction

endpackage

// ===== src/swept_tone_voice_generator.sv =====
// Top level of the swept tone voice generator: sequencer around one shared multiplier.
//
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid_i/in_ready_o   in_data_i  (start_req, mix_in)
//  out       output     out_valid_o/out_ready_i out_data_o (mix_out, voice_active, tone_done)
//  cfg       input      cfg_we_i                cfg_index_i, cfg_wdata_i
//
// After an accepting edge the block is busy and takes no new transaction until it is back
// in idle. The steps are the phase and sweep update, the registered sine table read, five
// passes through the shared 19 x 18 multiplier, each followed by its product register, the
// mix sum and the sample count, and the load of the output register; a voice that is not
// playing goes straight from the phase update to the output load.
// Reset clears the tone state and sets the registers to their defaults; the sine table
// is a constant built at elaboration and needs no fill.
// The input waits while a sample is being worked on. A finished result waits in the
// output register; the next transaction can be accepted while it waits to be taken, but
// the following result holds the sequencer in its last cycle until the first is taken.
module swept_tone_voice_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned LENGTH_BITS      = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  stvg_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output stvg_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_index_i,
  input  logic [stvg_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import stvg_pkg::*;

  localparam int unsigned IDX_BITS = $clog2(SINE_TABLE_DEPTH);

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  // Sine table built at elaboration from the quarter wave polynomial.
  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] f;
    logic [63:0] quad;
    logic [63:0] w;
    logic [63:0] u;
    logic [63:0] r;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      f    = 64'(k) << (32 - IDX_BITS);
      quad = (f >> 30) & 64'd3;
      w    = f & ((64'd1 << 30) - 64'd1);
      u    = quad[0] ? ((64'd1 << 30) - w) : w;
      r    = (quarter_sine(u) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      rom[k] = quad[1] ? -16'(r) : 16'(r);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Configuration registers.
  logic [31:0]        start_step_q;
  logic signed [31:0] step_slope_q;
  logic [1:0]         wave_shape_q;
  logic [15:0]        tone_length_q;
  logic [15:0]        tone_volume_q;
  logic [15:0]        filter_alpha_q;
  logic [15:0]        decay_factor_q;
  logic [15:0]        attack_step_q;

  // Tone state.
  state_e                  state_q, state_d;
  logic [PHASE_BITS-1:0]   phase_q, phase_d;
  logic [47:0]             step_q, step_d;
  logic [LENGTH_BITS-1:0]  count_q, count_d;
  logic signed [17:0]      filt_q, filt_d;
  logic [16:0]             attack_q, attack_d;
  logic [15:0]             decay_q, decay_d;
  logic                    running_q, running_d;

  // Per-sample working registers.
  logic signed [15:0]      mix_q, mix_d;
  logic [15:0]             env_q, env_d;
  logic signed [16:0]      voice_q, voice_d;
  logic                    active_q, active_d;
  logic                    done_q, done_d;
  logic signed [15:0]      rom_q;
  logic signed [36:0]      prod_q;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  out_t                    out_q, out_d;

  // Shared multiplier operands.
  logic signed [18:0]      mul_a;
  logic signed [17:0]      mul_b;

  // Combinational helpers.
  logic [LENGTH_BITS-1:0]  len;
  logic [16:0]             alpha_sat;
  logic [16:0]             vol_sat;
  logic [15:0]             p16;
  logic signed [16:0]      p_off;
  logic [16:0]             p_abs;
  logic signed [17:0]      wave_s;
  logic signed [18:0]      diff;
  logic signed [49:0]      step_sum;
  logic signed [18:0]      filt_sum;
  logic [17:0]             attack_sum;
  logic signed [17:0]      mix_sum;
  logic signed [15:0]      mix_sat;

  assign len       = LENGTH_BITS'(tone_length_q);
  assign alpha_sat = (filter_alpha_q > 16'd32768) ? 17'd32768 : {1'b0, filter_alpha_q};
  assign vol_sat   = (tone_volume_q > 16'd32768) ? 17'd32768 : {1'b0, tone_volume_q};

  // Wave shapes from the phase.
  assign p16   = phase_q[PHASE_BITS-1 -: 16];
  assign p_off = $signed({1'b0, p16}) - 17'sd32768;
  assign p_abs = p_off[16] ? 17'(-p_off) : 17'(p_off);

  always_comb begin
    unique case (wave_shape_q)
      SHAPE_TRIANGLE: wave_s = $signed({p_abs, 1'b0}) - 18'sd32768;
      SHAPE_SAWTOOTH: wave_s = 18'(p_off);
      default:        wave_s = 18'(rom_q);
    endcase
  end

  assign diff       = 19'(wave_s) - 19'(filt_q);
  assign step_sum   = $signed({2'b00, step_q}) + 50'(step_slope_q);
  assign filt_sum   = 19'(filt_q) + 19'(prod_q[32:15]);
  assign attack_sum = {1'b0, attack_q} + 18'(attack_step_q);
  assign mix_sum    = 18'(mix_q) + 18'(voice_q);
  assign mix_sat    = (mix_sum > 18'sd32767) ? 16'sh7fff :
                      (mix_sum < -18'sd32768) ? 16'sh8000 : 16'(mix_sum);

  // Registered sine table read and registered shared multiplier product.
  always_ff @(posedge clk_i) begin
    rom_q  <= SINE_ROM[phase_q[PHASE_BITS-1 -: IDX_BITS]];
    prod_q <= 37'(mul_a) * 37'(mul_b);
  end

  // Sequencer: next state, shared multiplier operands and state updates.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    step_d      = step_q;
    count_d     = count_q;
    filt_d      = filt_q;
    attack_d    = attack_q;
    decay_d     = decay_q;
    running_d   = running_q;
    mix_d       = mix_q;
    env_d       = env_q;
    voice_d     = voice_q;
    active_d    = active_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mix_d = in_data_i.mix_in;
          if (in_data_i.start_req) begin
            phase_d   = '0;
            step_d    = {start_step_q, 16'd0};
            count_d   = '0;
            filt_d    = '0;
            attack_d  = '0;
            decay_d   = 16'hffff;
            running_d = (len != '0);
          end
          state_d = ST_PHASE;
        end
      end
      ST_PHASE: begin
        voice_d  = '0;
        active_d = 1'b0;
        done_d   = 1'b0;
        if (running_q) begin
          phase_d = phase_q + step_q[16 +: PHASE_BITS];
          if (step_sum < 0) begin
            step_d = '0;
          end else if (step_sum[49:48] != 2'b00) begin
            step_d = '1;
          end else begin
            step_d = step_sum[47:0];
          end
          state_d = ST_WAVE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WAVE: begin
        state_d = ST_FMUL;
      end
      ST_FMUL: begin
        mul_a   = diff;
        mul_b   = 18'(alpha_sat);
        state_d = ST_FUPD;
      end
      ST_FUPD: begin
        filt_d  = 18'(filt_sum);
        mul_a   = 19'(attack_q);
        mul_b   = 18'(decay_q);
        state_d = ST_ENV;
      end
      ST_ENV: begin
        env_d    = prod_q[31:16];
        attack_d = (attack_sum > 18'd65536) ? 17'd65536 : 17'(attack_sum);
        mul_a    = 19'(decay_q);
        mul_b    = 18'(decay_factor_q);
        state_d  = ST_DEC;
      end
      ST_DEC: begin
        decay_d = prod_q[31:16];
        mul_a   = 19'(filt_q);
        mul_b   = 18'(env_q);
        state_d = ST_VMUL;
      end
      ST_VMUL: begin
        // The scaled filter value is signed; keep its sign into the volume pass.
        mul_a   = 19'($signed(prod_q[32:16]));
        mul_b   = 18'(vol_sat);
        state_d = ST_VSUM;
      end
      ST_VSUM: begin
        voice_d  = prod_q[31:15];
        active_d = 1'b1;
        count_d  = count_q + 1'b1;
        if (count_q + 1'b1 == len) begin
          done_d    = 1'b1;
          running_d = 1'b0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.mix_out      = mix_sat;
          out_d.voice_active = active_q;
          out_d.tone_done    = done_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= '0;
      step_q         <= '0;
      count_q        <= '0;
      filt_q         <= '0;
      attack_q       <= '0;
      decay_q        <= 16'hffff;
      running_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      start_step_q   <= '0;
      step_slope_q   <= '0;
      wave_shape_q   <= SHAPE_SINE;
      tone_length_q  <= '0;
      tone_volume_q  <= 16'd32768;
      filter_alpha_q <= 16'd32768;
      decay_factor_q <= 16'd65535;
      attack_step_q  <= 16'd186;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      count_q     <= count_d;
      filt_q      <= filt_d;
      attack_q    <= attack_d;
      decay_q     <= decay_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_START_STEP:   start_step_q   <= cfg_wdata_i;
          CFG_STEP_SLOPE:   step_slope_q   <= $signed(cfg_wdata_i);
          CFG_WAVE_SHAPE:   wave_shape_q   <= cfg_wdata_i[1:0];
          CFG_TONE_LENGTH:  tone_length_q  <= cfg_wdata_i[15:0];
          CFG_TONE_VOLUME:  tone_volume_q  <= cfg_wdata_i[15:0];
          CFG_FILTER_ALPHA: filter_alpha_q <= cfg_wdata_i[15:0];
          CFG_DECAY_FACTOR: decay_factor_q <= cfg_wdata_i[15:0];
          CFG_ATTACK_STEP:  attack_step_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    mix_q    <= mix_d;
    env_q    <= env_d;
    voice_q  <= voice_d;
    active_q <= active_d;
    done_q   <= done_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the swept tone voice generator.
`timescale 1ns / 100ps

module testbench;
  import stvg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam longint STEP_CEIL = (64'sd1 <<< 48) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Idling mode: 0 none, 1 sender, 2 receiver, 3 both.
  int idle_mode = 0;
  int failures = 0;
  int unsigned cycle_count = 0;
  out_t sample_q[$];

  // Shadow copy of the registers.
  logic [31:0] r_start_step, r_slope;
  logic [1:0] r_shape;
  logic [15:0] r_length, r_volume, r_alpha, r_decay, r_attack;

  // Shadow copy of the voice state.
  logic [31:0] phase;
  longint sweep_step;
  logic [15:0] samples_played;
  int filt;
  int attack_lvl;
  int decay_lvl;
  logic playing;
  int sine_lut[1024];

  swept_tone_voice_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Quarter-wave sine in Q30 by an odd degree-9 polynomial.
  function automatic longint unsigned qsin(longint unsigned u);
    longint unsigned sq, acc;
    sq = (u * u) >> 30;
    acc = 172273;
    acc = 5026996 - ((sq * acc) >> 30);
    acc = 85569306 - ((sq * acc) >> 30);
    acc = 693598667 - ((sq * acc) >> 30);
    acc = 1686629713 - ((sq * acc) >> 30);
    return (u * acc) >> 30;
  endfunction

  function automatic void fill_sine_lut();
    longint unsigned frac, quad, w, u, r;
    for (int k = 0; k < 1024; k++) begin
      frac = longint'(k) << 22;
      quad = (frac >> 30) & 3;
      w = frac & ((64'd1 << 30) - 1);
      u = quad[0] ? ((64'd1 << 30) - w) : w;
      r = (qsin(u) + 16384) >> 15;
      if (r > 32767) r = 32767;
      sine_lut[k] = (quad >= 2) ? -int'(r) : int'(r);
    end
  endfunction

  function automatic void reset_shadow();
    r_start_step = 0; r_slope = 0; r_shape = SHAPE_SINE; r_length = 0;
    r_volume = 16'd32768; r_alpha = 16'd32768; r_decay = 16'd65535; r_attack = 16'd186;
    phase = 0; sweep_step = 0; samples_played = 0; filt = 0;
    attack_lvl = 0; decay_lvl = 65535; playing = 1'b0;
  endfunction

  // Works out the output sample for one accepted input sample.
  function automatic out_t voice_sample(in_t item);
    out_t res;
    longint mix, wave, voice, env, alpha, vol;
    logic [15:0] p16;
    mix = item.mix_in;
    res = '0;
    if (item.start_req) begin
      phase = 0;
      sweep_step = longint'(r_start_step) << 16;
      samples_played = 0; filt = 0; attack_lvl = 0; decay_lvl = 65535;
      playing = (r_length != 0);
    end
    if (playing) begin
      alpha = (r_alpha > 16'd32768) ? 32768 : r_alpha;
      vol = (r_volume > 16'd32768) ? 32768 : r_volume;
      phase = phase + 32'(sweep_step >> 16);
      sweep_step = sweep_step + longint'($signed(r_slope));
      if (sweep_step < 0) sweep_step = 0;
      if (sweep_step > STEP_CEIL) sweep_step = STEP_CEIL;
      p16 = phase[31:16];
      case (r_shape)
        SHAPE_TRIANGLE: begin
          wave = longint'(p16) - 32768;
          if (wave < 0) wave = -wave;
          wave = 2 * wave - 32768;
        end
        SHAPE_SAWTOOTH: wave = longint'(p16) - 32768;
        default: wave = sine_lut[phase[31:22]];
      endcase
      filt = filt + int'((alpha * (wave - filt)) >>> 15);
      env = (longint'(attack_lvl) * decay_lvl) >> 16;
      attack_lvl = attack_lvl + r_attack;
      if (attack_lvl > 65536) attack_lvl = 65536;
      decay_lvl = int'((longint'(decay_lvl) * r_decay) >> 16);
      voice = (longint'(filt) * env) >>> 16;
      voice = (voice * vol) >>> 15;
      mix = mix + voice;
      if (mix > 32767) mix = 32767;
      if (mix < -32768) mix = -32768;
      res.voice_active = 1'b1;
      if (16'(samples_played + 16'd1) == r_length) begin
        res.tone_done = 1'b1;
        playing = 1'b0;
      end
      samples_played = samples_played + 16'd1;
    end
    res.mix_out = 16'(mix);
    return res;
  endfunction

  // Sends one sample and records its expected output on acceptance.
  task automatic send_sample(input logic start, input logic [15:0] mix);
    int gap_pct;
    in_valid <= 1'b1;
    in_data <= '{start_req: start, mix_in: mix};
    do @(posedge clk_i); while (!in_ready);
    sample_q.insert(sample_q.size(), voice_sample('{start_req: start, mix_in: mix}));
    gap_pct = (idle_mode == 1) ? 79 : (idle_mode == 3) ? 35 : 0;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // Waits until every expected sample is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Drives one register write; write_all drops the enable after the last one.
  task automatic write_reg(input cfg_index_e idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    case (idx)
      CFG_START_STEP:   r_start_step = value;
      CFG_STEP_SLOPE:   r_slope = value;
      CFG_WAVE_SHAPE:   r_shape = value[1:0];
      CFG_TONE_LENGTH:  r_length = value[15:0];
      CFG_TONE_VOLUME:  r_volume = value[15:0];
      CFG_FILTER_ALPHA: r_alpha = value[15:0];
      CFG_DECAY_FACTOR: r_decay = value[15:0];
      default:          r_attack = value[15:0];
    endcase
  endtask

  task automatic write_all(input logic [31:0] step, input logic [31:0] slope,
                           input logic [1:0] shape, input logic [15:0] len,
                           input logic [15:0] vol, input logic [15:0] alpha,
                           input logic [15:0] decay, input logic [15:0] atk);
    write_reg(CFG_START_STEP, step);
    write_reg(CFG_STEP_SLOPE, slope);
    write_reg(CFG_WAVE_SHAPE, 32'(shape));
    write_reg(CFG_TONE_LENGTH, 32'(len));
    write_reg(CFG_TONE_VOLUME, 32'(vol));
    write_reg(CFG_FILTER_ALPHA, 32'(alpha));
    write_reg(CFG_DECAY_FACTOR, 32'(decay));
    write_reg(CFG_ATTACK_STEP, 32'(atk));
    cfg_we <= 1'b0;
  endtask

  // Reset defaults: zero length keeps the voice silent even on a start.
  task automatic test_idle_passthrough();
    send_sample(1'b1, 16'h7FFF);
    send_sample(1'b0, 16'h8000);
    drain();
  endtask

  // Every wave shape, the unused code too, at loud full-attack settings.
  task automatic test_wave_shapes();
    for (int sh = 0; sh < 4; sh++) begin
      write_all(32'h0800_0000, 32'h0001_0000, 2'(sh), 16'd3, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF);
      send_sample(1'b1, 16'h7FFF);
      send_sample(1'b0, 16'h8000);
      send_sample(1'b0, 16'h0000);
      drain();
    end
  endtask

  // Sweep driven to its lower clamp, alpha of zero, and a restart mid-tone.
  task automatic test_sweep_and_restart();
    write_all(32'h8000_0000, 32'h7FFF_FFFF, SHAPE_SAWTOOTH, 16'hFFFF, 16'd32768, 16'd0,
              16'd0, 16'd1);
    send_sample(1'b1, 16'h1234);
    send_sample(1'b0, 16'hEDCB);
    drain();
    write_all(32'd0, 32'h8000_0000, SHAPE_TRIANGLE, 16'd5, 16'd20000, 16'd1,
              16'd40000, 16'd30000);
    send_sample(1'b1, 16'h4000);
    send_sample(1'b0, 16'hC000);
    send_sample(1'b1, 16'h0001);
    send_sample(1'b0, 16'hFFFF);
    drain();
  endtask

  task automatic randomize_regs();
    logic [15:0] len;
    case ($urandom_range(3))
      0: len = 16'($urandom_range(8, 1));
      1: len = 16'($urandom_range(80, 9));
      2: len = 16'($urandom);
      default: len = 16'($urandom_range(1) ? 0 : 16'hFFFF);
    endcase
    write_all($urandom_range(1) ? $urandom : $urandom_range(32'h0400_0000),
              $urandom_range(1) ? $urandom : 32'($signed(16'($urandom))),
              2'($urandom), len, 16'($urandom), 16'($urandom),
              $urandom_range(1) ? 16'($urandom_range(65535, 60000)) : 16'($urandom),
              16'($urandom));
  endtask

  // Random tones with random content across every idling mode.
  task automatic test_random_tones();
    for (int m = 0; m < 4; m++) begin
      idle_mode = m;
      for (int blk = 0; blk < 4; blk++) begin
        randomize_regs();
        for (int n = 0; n < 106; n++)
          send_sample((n == 0) || ($urandom_range(39) == 0), 16'($urandom));
        drain();
      end
    end
  endtask

  // Receiver stalls follow the current idling mode.
  always @(posedge clk_i) begin
    case (idle_mode)
      2: out_ready <= ($urandom_range(99) >= 79);
      3: out_ready <= ($urandom_range(99) >= 35);
      default: out_ready <= 1'b1;
    endcase
  end

  // Compares each output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        $display("%0t: unexpected output %p", $time, out_data);
        failures++;
      end else begin
        if (out_data.mix_out !== sample_q[0].mix_out) begin
          $display("%0t: mix_out expected %0d actual %0d", $time,
                   sample_q[0].mix_out, out_data.mix_out);
          failures++;
        end
        if (out_data.voice_active !== sample_q[0].voice_active) begin
          $display("%0t: voice_active expected %b actual %b", $time,
                   sample_q[0].voice_active, out_data.voice_active);
          failures++;
        end
        if (out_data.tone_done !== sample_q[0].tone_done) begin
          $display("%0t: tone_done expected %b actual %b", $time,
                   sample_q[0].tone_done, out_data.tone_done);
          failures++;
        end
        void'(sample_q.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    fill_sine_lut();
    reset_shadow();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_passthrough();
    test_wave_shapes();
    test_sweep_and_restart();
    test_random_tones();
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/stvg_pkg.sv
src/swept_tone_voice_generator.sv
dv/testbench.sv
